FILE: sv/sliding_window_receiver_unit_macros.svh
// assertion macros used by the sliding window receiver datapath
`ifndef SLIDING_WINDOW_RECEIVER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_RECEIVER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define SWR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define SWR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SWR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define SWR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/swr_pkg.sv
// shared constants, codes and controller/datapath types of the window receiver
package swr_pkg;

   // sizing
   localparam int WINDOW      = 8;
   localparam int SEQ_SPACE   = 256;
   localparam int LEN_LIMIT   = 1024;
   localparam int SLOT_W      = $clog2(WINDOW);
   localparam int SEQ_W       = $clog2(SEQ_SPACE);
   localparam int SEQ_FIELD_W = 32;
   localparam int FLAG_W      = 8;
   localparam int LEN_W       = 16;
   localparam int SLOT_OUT_W  = 3;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int ISEQ_W      = 8;

   // control byte codes
   localparam logic [FLAG_W-1:0] CTL_DATA       = 8'h00;
   localparam logic [FLAG_W-1:0] CTL_CONNECT    = 8'h01;
   localparam logic [FLAG_W-1:0] CTL_DISCONNECT = 8'h02;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SEQ  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DATA_LEN = 8'd1;

   typedef enum logic [2:0] {
      KIND_REJECT     = 3'd0,
      KIND_DELIVER    = 3'd1,
      KIND_ACK        = 3'd2,
      KIND_FINAL_ACK  = 3'd3,
      KIND_CONNECT    = 3'd4,
      KIND_NOTHING    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ACK_FLAG  = 3'd1,
      ST_CONTROL   = 3'd2,
      ST_SEQ_RANGE = 3'd3,
      ST_WINDOW    = 3'd4,
      ST_DUPLICATE = 3'd5,
      ST_LENGTH    = 3'd6,
      ST_PHASE     = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_DECIDE,
      S_ONE,
      S_READ,
      S_DELIV,
      S_ACK
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
      logic decide;
      logic load_one;
      logic load_deliver;
      logic load_ack;
   } swr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic single;
      logic head_full;
      logic succ_full;
      logic out_free;
   } swr_stat_type;

endpackage

FILE: sv/swr_ctrl.sv
// controller state machine sequencing check, ack decision and delivery walk
module swr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  swr_pkg::swr_stat_type stat,
   output swr_pkg::swr_cmd_type  cmd
);
   import swr_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = stat.single ? S_ONE : S_DECIDE;
         end
         S_DECIDE: begin
            state_in = stat.head_full ? S_READ : S_ONE;
         end
         S_ONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         S_READ: begin
            state_in = S_DELIV;
         end
         S_DELIV: begin
            if (stat.out_free) state_in = stat.succ_full ? S_READ : S_ACK;
         end
         S_ACK: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      req_tready       = 1'b0;
      cmd              = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_EVAL: begin
            cmd.commit = 1'b1;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
         end
         S_ONE: begin
            cmd.load_one = stat.out_free;
         end
         S_READ: begin
         end
         S_DELIV: begin
            cmd.load_deliver = stat.out_free;
         end
         S_ACK: begin
            cmd.load_ack = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: sv/swr_dp.sv
// datapath: header checks, slot buffer, window state and result register
`include "sliding_window_receiver_unit_macros.svh"
module swr_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swr_pkg::swr_cmd_type                 cmd,
   output swr_pkg::swr_stat_type                stat,
   input  logic [swr_pkg::SEQ_FIELD_W-1:0]      in_seq,
   input  logic [swr_pkg::FLAG_W-1:0]           in_ack,
   input  logic [swr_pkg::FLAG_W-1:0]           in_ctl,
   input  logic [swr_pkg::LEN_W-1:0]            in_len,
   input  logic                                 csr_write,
   input  logic [swr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [swr_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                 rsp_tready,
   output logic                                 rsp_valid,
   output swr_pkg::kind_type                    rsp_kind,
   output logic [swr_pkg::SEQ_FIELD_W-1:0]      rsp_seq,
   output logic [swr_pkg::LEN_W-1:0]            rsp_len,
   output logic [swr_pkg::SLOT_OUT_W-1:0]       rsp_slot,
   output swr_pkg::status_type                  rsp_status,
   output logic                                 rsp_last
);
   import swr_pkg::*;

   // captured header
   logic [SEQ_FIELD_W-1:0] seq_ff;
   logic [FLAG_W-1:0]      ack_ff;
   logic [FLAG_W-1:0]      ctl_ff;
   logic [LEN_W-1:0]       len_ff;

   // protocol state
   logic [WINDOW-1:0]      valid_ff;
   logic [LEN_W-1:0]       mem [WINDOW];
   logic [LEN_W-1:0]       rd_data_ff;
   logic [SEQ_W-1:0]       next_ff;
   logic [SEQ_W-1:0]       last_acc_ff;
   logic [SEQ_W-1:0]       cur_ff;
   logic [LEN_W-1:0]       max_len_ff;
   logic                   end_seen_ff;
   logic [SEQ_FIELD_W-1:0] end_seq_ff;
   logic                   link_up_ff;
   logic                   done_ff;

   // pending single result
   kind_type               pend_kind_ff;
   status_type             pend_status_ff;
   logic [SEQ_FIELD_W-1:0] pend_seq_ff;

   // output register
   logic                   out_valid_ff;
   kind_type               out_kind_ff;
   logic [SEQ_FIELD_W-1:0] out_seq_ff;
   logic [LEN_W-1:0]       out_len_ff;
   logic [SLOT_OUT_W-1:0]  out_slot_ff;
   status_type             out_status_ff;
   logic                   out_last_ff;

   // evaluation results
   logic                   ev_single;
   kind_type               ev_kind;
   status_type             ev_status;
   logic                   ev_connect;
   logic                   ev_end;
   logic                   ev_store;
   logic [SEQ_W-1:0]       seq_gap;
   logic [SEQ_W-1:0]       span;
   logic [SLOT_W-1:0]      in_slot;
   logic [LEN_W-1:0]       limit;
   logic [SEQ_W-1:0]       prev_seq;
   logic                   is_final;
   logic [SEQ_W-1:0]       succ_seq;
   logic [SLOT_W-1:0]      cur_slot;
   logic                   out_free;

   assign seq_gap  = seq_ff[SEQ_W-1:0] - next_ff;
   assign span     = last_acc_ff - next_ff;
   assign in_slot  = seq_ff[SLOT_W-1:0];
   assign limit    = (max_len_ff < LEN_W'(LEN_LIMIT)) ? max_len_ff : LEN_W'(LEN_LIMIT);
   assign prev_seq = next_ff - SEQ_W'(1);
   assign is_final = end_seen_ff && (SEQ_FIELD_W'(prev_seq) == end_seq_ff);
   assign succ_seq = cur_ff + SEQ_W'(1);
   assign cur_slot = cur_ff[SLOT_W-1:0];
   assign out_free = !out_valid_ff || rsp_tready;

   // header classification
   always_comb begin
      ev_single  = 1'b1;
      ev_kind    = KIND_REJECT;
      ev_status  = ST_OK;
      ev_connect = 1'b0;
      ev_end     = 1'b0;
      ev_store   = 1'b0;
      priority if (done_ff) begin
         ev_status = ST_PHASE;
      end else if (!link_up_ff) begin
         priority if (ack_ff != '0) begin
            ev_status = ST_ACK_FLAG;
         end else if (ctl_ff == CTL_DATA || ctl_ff == CTL_DISCONNECT) begin
            ev_status = ST_PHASE;
         end else if (ctl_ff != CTL_CONNECT) begin
            ev_status = ST_CONTROL;
         end else if (len_ff != '0) begin
            ev_status = ST_LENGTH;
         end else begin
            ev_kind    = KIND_CONNECT;
            ev_connect = 1'b1;
         end
      end else if (ack_ff != '0) begin
         ev_status = ST_ACK_FLAG;
      end else if (ctl_ff == CTL_CONNECT) begin
         ev_status = ST_PHASE;
      end else if (ctl_ff == CTL_DISCONNECT) begin
         if (len_ff != '0) begin
            ev_status = ST_LENGTH;
         end else begin
            ev_single = 1'b0;
            ev_end    = 1'b1;
         end
      end else if (ctl_ff != CTL_DATA) begin
         ev_status = ST_CONTROL;
      end else if (seq_ff >= SEQ_FIELD_W'(SEQ_SPACE)) begin
         ev_status = ST_SEQ_RANGE;
      end else if (seq_gap > span) begin
         ev_status = ST_WINDOW;
      end else if (valid_ff[in_slot]) begin
         ev_status = ST_DUPLICATE;
      end else if (len_ff > limit) begin
         ev_status = ST_LENGTH;
      end else begin
         ev_single = 1'b0;
         ev_store  = 1'b1;
      end
   end

   // header capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff <= in_seq;
         ack_ff <= in_ack;
         ctl_ff <= in_ctl;
         len_ff <= in_len;
      end
   end

   // slot length memory, registered read at the walk position
   always_ff @(posedge clock) begin
      if (cmd.commit && ev_store) begin
         mem[in_slot] <= len_ff;
      end
      rd_data_ff <= mem[cur_slot];
   end

   // window and link state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         next_ff     <= '0;
         last_acc_ff <= SEQ_W'(WINDOW - 1);
         max_len_ff  <= LEN_W'(LEN_LIMIT);
         end_seen_ff <= 1'b0;
         end_seq_ff  <= '0;
         link_up_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         // register writes
         if (csr_write && csr_index == CSR_INITIAL_SEQ && !link_up_ff) begin
            next_ff     <= SEQ_W'(csr_data[ISEQ_W-1:0]);
            last_acc_ff <= SEQ_W'(csr_data[ISEQ_W-1:0]) + SEQ_W'(WINDOW - 1);
         end
         if (csr_write && csr_index == CSR_MAX_DATA_LEN) begin
            max_len_ff <= csr_data[LEN_W-1:0];
         end
         // accepted header effects
         if (cmd.commit) begin
            if (ev_connect) link_up_ff <= 1'b1;
            if (ev_end) begin
               end_seen_ff <= 1'b1;
               end_seq_ff  <= seq_ff;
            end
            if (ev_store) valid_ff[in_slot] <= (len_ff != '0);
         end
         // final ack closes the transfer
         if (cmd.decide && !valid_ff[next_ff[SLOT_W-1:0]] && is_final) begin
            done_ff <= 1'b1;
         end
         // delivered slot becomes empty
         if (cmd.load_deliver) begin
            valid_ff[cur_slot] <= 1'b0;
         end
         // cumulative ack moves the window
         if (cmd.load_ack) begin
            next_ff     <= succ_seq;
            last_acc_ff <= cur_ff + SEQ_W'(WINDOW);
         end
      end
   end

   // walk position and pending single result
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pend_kind_ff   <= ev_kind;
         pend_status_ff <= ev_status;
         pend_seq_ff    <= seq_ff;
      end
      if (cmd.decide) begin
         cur_ff         <= next_ff;
         pend_status_ff <= ST_OK;
         if (is_final) begin
            pend_kind_ff <= KIND_FINAL_ACK;
            pend_seq_ff  <= SEQ_FIELD_W'(prev_seq);
         end else begin
            pend_kind_ff <= KIND_NOTHING;
            pend_seq_ff  <= SEQ_FIELD_W'(next_ff);
         end
      end
      if (cmd.load_deliver && valid_ff[succ_seq[SLOT_W-1:0]]) begin
         cur_ff <= succ_seq;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_one || cmd.load_deliver || cmd.load_ack) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      priority if (cmd.load_one) begin
         out_kind_ff   <= pend_kind_ff;
         out_seq_ff    <= pend_seq_ff;
         out_len_ff    <= '0;
         out_slot_ff   <= '0;
         out_status_ff <= pend_status_ff;
         out_last_ff   <= 1'b1;
      end else if (cmd.load_deliver) begin
         out_kind_ff   <= KIND_DELIVER;
         out_seq_ff    <= SEQ_FIELD_W'(cur_ff);
         out_len_ff    <= rd_data_ff;
         out_slot_ff   <= SLOT_OUT_W'(cur_slot);
         out_status_ff <= ST_OK;
         out_last_ff   <= 1'b0;
      end else if (cmd.load_ack) begin
         out_kind_ff   <= KIND_ACK;
         out_seq_ff    <= SEQ_FIELD_W'(cur_ff);
         out_len_ff    <= '0;
         out_slot_ff   <= '0;
         out_status_ff <= ST_OK;
         out_last_ff   <= 1'b1;
      end else begin
      end
   end

   // status to the controller
   assign stat = '{single:    ev_single,
                   head_full: valid_ff[next_ff[SLOT_W-1:0]],
                   succ_full: valid_ff[succ_seq[SLOT_W-1:0]],
                   out_free:  out_free};

   assign rsp_valid  = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_seq    = out_seq_ff;
   assign rsp_len    = out_len_ff;
   assign rsp_slot   = out_slot_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

   // checks
   `SWR_ASSERT_SAME(a_load_when_free, clock, reset, cmd.load_one || cmd.load_deliver || cmd.load_ack, out_free, "result register overwritten")
   `SWR_ASSERT_SAME(a_deliver_filled, clock, reset, cmd.load_deliver, valid_ff[cur_slot], "delivery from empty slot")
   `SWR_ASSERT_NEXT(a_ack_head_empty, clock, reset, cmd.load_ack, !valid_ff[next_ff[SLOT_W-1:0]], "ack left head slot filled")
   `SWR_ASSERT_NEXT(a_done_sticky, clock, reset, done_ff, done_ff, "transfer done flag cleared")

endmodule

FILE: sv/sliding_window_receiver_unit.sv
// Sliding window receiver top level: stream ports, controller and datapath.
// A rejected, connect or idle-ack header gives its one result through states EVAL and ONE
// after the input transfer; an ack decision adds DECIDE; each delivered slot takes READ
// and DELIV (registered read of the slot length memory), then ACK; only IDLE takes a header.
// Up to 8 deliveries per header; ONE, DELIV and ACK wait for a free result register.
// Synchronous active high reset empties all slots at once; no clearing pass.
module sliding_window_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // seq_field[31:0], payload_len[47:32]
   input  logic [15:0] req_tuser,  // ack_flag[7:0], control_flag[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // seq_out[31:0], len_out[47:32], slot_out[50:48],
                                   // status[53:51], zero fill[55:54]
   output logic [2:0]  rsp_tuser,  // kind[2:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);
   import swr_pkg::*;

   swr_cmd_type            cmd;
   swr_stat_type           stat;
   kind_type               kind;
   status_type             status;
   logic [SEQ_FIELD_W-1:0] seq_out;
   logic [LEN_W-1:0]       len_out;
   logic [SLOT_OUT_W-1:0]  slot_out;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   swr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   swr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_seq     (req_tdata[31:0]),
      .in_ack     (req_tuser[7:0]),
      .in_ctl     (req_tuser[15:8]),
      .in_len     (req_tdata[47:32]),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_kind   (kind),
      .rsp_seq    (seq_out),
      .rsp_len    (len_out),
      .rsp_slot   (slot_out),
      .rsp_status (status),
      .rsp_last   (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {2'b00, status, slot_out, len_out, seq_out};
   assign rsp_tuser = kind;

endmodule

FILE: tb/sv/tb_sliding_window_receiver_unit.sv
// self-checking testbench for the sliding window receiver unit
module tb_sliding_window_receiver_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import swr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 40;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_LIMIT);

   // one received packet header
   typedef struct packed {
      logic [SEQ_FIELD_W-1:0] seq;
      logic [FLAG_W-1:0]      ack_flag;
      logic [FLAG_W-1:0]      control;
      logic [LEN_W-1:0]       len;
   } header_type;

   // one result record
   typedef struct {
      kind_type               kind;
      logic [SEQ_FIELD_W-1:0] seq;
      logic [LEN_W-1:0]       len;
      logic [SLOT_OUT_W-1:0]  slot;
      status_type             status;
      logic                   last;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // seq_field[31:0], payload_len[47:32]
   logic [15:0] req_tuser = '0;   // ack_flag[7:0], control_flag[15:8]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // seq_out[31:0], len_out[47:32], slot_out[50:48],
                                  // status[53:51], zero fill[55:54]
   logic [2:0]  rsp_tuser;        // kind[2:0]
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // predicted receiver state and configuration
   logic [LEN_W-1:0]       slot_len [WINDOW];
   logic [SEQ_W-1:0]       next_seq;
   logic [SEQ_W-1:0]       last_ok;
   logic                   end_seen;
   logic [SEQ_FIELD_W-1:0] end_seq;
   logic                   link_up;
   logic                   transfer_done;
   logic [LEN_W-1:0]       cfg_max_len;

   reply_type awaited_replies [$];
   reply_type step_replies [$];
   reply_type want_reply;

   int send_idle_pct = 22;
   int recv_stall_pct = 51;
   int mismatches = 0;
   int cycle_count = 0;

   sliding_window_receiver_unit DUT (.*);

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [SEQ_FIELD_W-1:0] seq_word(input logic [SEQ_W-1:0] s);
      return {{(SEQ_FIELD_W-SEQ_W){1'b0}}, s};
   endfunction

   function automatic header_type hdr(input logic [SEQ_FIELD_W-1:0] sq, input logic [7:0] ackf,
                                      input logic [7:0] ctl, input logic [LEN_W-1:0] ln);
      header_type h;
      h.seq = sq;
      h.ack_flag = ackf;
      h.control = ctl;
      h.len = ln;
      return h;
   endfunction

   // accepted length is bounded by both the register and the buffer size
   function automatic logic [LEN_W-1:0] len_cap();
      return (cfg_max_len < LEN_CAP) ? cfg_max_len : LEN_CAP;
   endfunction

   function automatic void load_window(input logic [SEQ_W-1:0] start);
      next_seq = start;
      last_ok = start + SEQ_W'(WINDOW - 1);
   endfunction

   function automatic void add_reply(input kind_type k, input logic [SEQ_FIELD_W-1:0] sq,
                                     input logic [LEN_W-1:0] ln,
                                     input logic [SLOT_OUT_W-1:0] sl, input status_type st);
      reply_type r;
      r.kind = k;
      r.seq = sq;
      r.len = ln;
      r.slot = sl;
      r.status = st;
      r.last = 1'b0;
      step_replies.push_back(r);
   endfunction

   // expected results of one accepted header, state updated as the block does
   function automatic void window_response(input header_type h);
      status_type       bad;
      logic             accepted;
      logic             walking;
      logic [SEQ_W-1:0] gap_ahead, reach, cur, nxt, prev;
      logic [SLOT_W-1:0] s;
      reply_type        r;
      step_replies.delete();
      bad = ST_OK;
      accepted = 1'b0;
      gap_ahead = h.seq[SEQ_W-1:0] - next_seq;
      reach = last_ok - next_seq;
      s = h.seq[SLOT_W-1:0];
      if (transfer_done) begin
         bad = ST_PHASE;
      end else if (!link_up) begin
         if (h.ack_flag != 0) bad = ST_ACK_FLAG;
         else if (h.control == CTL_DATA || h.control == CTL_DISCONNECT) bad = ST_PHASE;
         else if (h.control != CTL_CONNECT) bad = ST_CONTROL;
         else if (h.len != 0) bad = ST_LENGTH;
         else begin
            link_up = 1'b1;
            add_reply(KIND_CONNECT, h.seq, '0, '0, ST_OK);
         end
      end else if (h.ack_flag != 0) begin
         bad = ST_ACK_FLAG;
      end else if (h.control == CTL_CONNECT) begin
         bad = ST_PHASE;
      end else if (h.control == CTL_DISCONNECT) begin
         if (h.len != 0) bad = ST_LENGTH;
         else begin
            end_seen = 1'b1;
            end_seq = h.seq;
            accepted = 1'b1;
         end
      end else if (h.control != CTL_DATA) begin
         bad = ST_CONTROL;
      end else if (h.seq >= SEQ_SPACE) begin
         bad = ST_SEQ_RANGE;
      end else if (gap_ahead > reach) begin
         bad = ST_WINDOW;
      end else if (slot_len[s] != 0) begin
         bad = ST_DUPLICATE;
      end else if (h.len > len_cap()) begin
         bad = ST_LENGTH;
      end else begin
         slot_len[s] = h.len;
         accepted = 1'b1;
      end

      if (bad != ST_OK) begin
         add_reply(KIND_REJECT, h.seq, '0, '0, bad);
      end else if (accepted) begin
         // ack decision
         if (slot_len[next_seq[SLOT_W-1:0]] == 0) begin
            prev = next_seq - 1'b1;
            if (end_seen && seq_word(prev) == end_seq) begin
               transfer_done = 1'b1;
               add_reply(KIND_FINAL_ACK, seq_word(prev), '0, '0, ST_OK);
            end else begin
               add_reply(KIND_NOTHING, seq_word(next_seq), '0, '0, ST_OK);
            end
         end else begin
            // deliver consecutive filled slots, then one cumulative ack
            cur = next_seq;
            walking = 1'b1;
            while (walking) begin
               s = cur[SLOT_W-1:0];
               add_reply(KIND_DELIVER, seq_word(cur), slot_len[s], s, ST_OK);
               slot_len[s] = '0;
               nxt = cur + 1'b1;
               if (slot_len[nxt[SLOT_W-1:0]] == 0) begin
                  add_reply(KIND_ACK, seq_word(cur), '0, '0, ST_OK);
                  load_window(nxt);
                  walking = 1'b0;
               end else begin
                  cur = nxt;
               end
            end
         end
      end

      r = step_replies.pop_back();
      r.last = 1'b1;
      step_replies.push_back(r);
      foreach (step_replies[i]) awaited_replies.push_back(step_replies[i]);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result, expected none, actual kind %h seq %h",
                     $time, rsp_tuser, rsp_tdata[31:0]);
         end else begin
            want_reply = awaited_replies.pop_front();
            check_field("kind", 32'(want_reply.kind), 32'(rsp_tuser));
            check_field("seq_out", want_reply.seq, rsp_tdata[31:0]);
            check_field("len_out", 32'(want_reply.len), 32'(rsp_tdata[47:32]));
            check_field("slot_out", 32'(want_reply.slot), 32'(rsp_tdata[50:48]));
            check_field("status", 32'(want_reply.status), 32'(rsp_tdata[53:51]));
            check_field("last", 32'(want_reply.last), 32'(rsp_tlast));
         end
      end
   end

   // one header transfer, with an optional idle stretch in front
   task automatic send_header(input header_type h);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {h.len, h.seq};
      req_tuser <= {h.control, h.ack_flag};
      do @(posedge clock); while (!req_tready);
      window_response(h);
   endtask

   // hold the sender until every expected result has come
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_replies.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_INITIAL_SEQ) begin
         if (!link_up) load_window(value[SEQ_W-1:0]);
      end else if (idx == CSR_MAX_DATA_LEN) begin
         cfg_max_len = value;
      end
   endtask

   task automatic program_registers(input logic set_seq, input logic [15:0] seq_value,
                                    input logic set_len, input logic [15:0] len_value);
      wait_for_replies();
      if (set_seq) write_csr(CSR_INITIAL_SEQ, seq_value);
      if (set_len) write_csr(CSR_MAX_DATA_LEN, len_value);
      csr_valid <= 1'b0;
   endtask

   // every reject reason while the link is down
   task automatic test_link_down();
      send_header(hdr(32'h0000_0000, 8'hFF, CTL_CONNECT, 16'h0000));
      send_header(hdr(32'h0000_0000, 8'h00, CTL_DATA, 16'h0010));
      send_header(hdr(32'h0000_0003, 8'h00, CTL_DISCONNECT, 16'h0000));
      send_header(hdr(32'h0000_0001, 8'h00, 8'hFF, 16'h0000));
      send_header(hdr(32'h0000_0001, 8'h00, 8'h03, 16'h0000));
      send_header(hdr(32'h0000_0002, 8'h00, CTL_CONNECT, 16'hFFFF));
   endtask

   task automatic test_connect();
      send_header(hdr(32'hFFFF_FFFF, 8'h00, CTL_CONNECT, 16'h0000));
   endtask

   // header checks once the link is up
   task automatic test_header_checks();
      logic [SEQ_W-1:0] base;
      base = next_seq;
      send_header(hdr(32'h0000_0005, 8'h00, CTL_CONNECT, 16'h0000));
      send_header(hdr(seq_word(base), 8'h80, CTL_DATA, 16'h0001));
      send_header(hdr(seq_word(base), 8'h00, 8'h80, 16'h0000));
      send_header(hdr(seq_word(base), 8'h00, 8'h03, 16'h0000));
      send_header(hdr(32'h1234_5678, 8'h00, CTL_DISCONNECT, 16'h0001));
      send_header(hdr(32'h0000_0100, 8'h00, CTL_DATA, 16'h0001));
      send_header(hdr(32'hFFFF_FFFF, 8'h00, CTL_DATA, 16'h0001));
      send_header(hdr(seq_word(base + 8'd8), 8'h00, CTL_DATA, 16'h0001));
      send_header(hdr(seq_word(base - 8'd1), 8'h00, CTL_DATA, 16'h0001));
   endtask

   // out of order fill, duplicate, length limit, zero length and wrap of the window
   task automatic test_window_wrap();
      logic [SEQ_W-1:0] base;
      base = next_seq;
      send_header(hdr(seq_word(base + 8'd2), 8'h00, CTL_DATA, LEN_CAP));
      send_header(hdr(seq_word(base + 8'd2), 8'h00, CTL_DATA, 16'h0005));
      send_header(hdr(seq_word(base + 8'd1), 8'h00, CTL_DATA, LEN_CAP + 16'd1));
      send_header(hdr(seq_word(base + 8'd1), 8'h00, CTL_DATA, 16'h0000));
      send_header(hdr(seq_word(base + 8'd1), 8'h00, CTL_DATA, 16'h0001));
      send_header(hdr(seq_word(base), 8'h00, CTL_DATA, 16'h00FF));
      base = next_seq;
      send_header(hdr(seq_word(base + 8'd1), 8'h00, CTL_DATA, 16'h0003));
      send_header(hdr(seq_word(base), 8'h00, CTL_DATA, 16'h0002));
   endtask

   function automatic logic [LEN_W-1:0] data_length(input logic [LEN_W-1:0] cap);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return cap;
      if (r == 2 && cap != 16'hFFFF) return cap + 16'd1;
      return LEN_W'($urandom_range(1, cap));
   endfunction

   // mostly in-window data with random content, plus noise and stray disconnects
   task automatic test_random_traffic(input int count);
      header_type       h;
      int               pick;
      logic [SEQ_W-1:0] offset;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         h = hdr(32'h0, 8'h00, CTL_DATA, data_length(len_cap()));
         if (pick < 30) begin
            h.seq = seq_word(next_seq);
         end else if (pick < 65) begin
            offset = SEQ_W'($urandom_range(1, WINDOW - 1));
            h.seq = seq_word(next_seq + offset);
         end else if (pick < 72) begin
            offset = SEQ_W'($urandom_range(WINDOW, SEQ_SPACE - 1));
            h.seq = seq_word(next_seq + offset);
         end else if (pick < 80) begin
            h.control = CTL_DISCONNECT;
            h.seq = $urandom;
            if ($urandom_range(0, 3) == 0) h.len = LEN_W'($urandom_range(1, 65535));
            else h.len = '0;
         end else begin
            h.seq = $urandom;
            h.len = LEN_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 2) == 0) h.ack_flag = FLAG_W'($urandom_range(1, 255));
            case ($urandom_range(0, 3))
               0: h.control = CTL_CONNECT;
               1: h.control = CTL_DISCONNECT;
               2: h.control = CTL_DATA;
               default: h.control = FLAG_W'($urandom_range(3, 255));
            endcase
         end
         // a stray disconnect must never match the acked sequence
         if (h.control == CTL_DISCONNECT) h.seq[SEQ_W] = 1'b1;
         send_header(h);
      end
   endtask

   // fill the whole window backwards so one header releases every slot
   task automatic test_full_window();
      logic [SEQ_W-1:0] base;
      base = next_seq;
      for (int k = WINDOW - 1; k >= 0; k--) begin
         send_header(hdr(seq_word(base + SEQ_W'(k)), 8'h00, CTL_DATA,
                         LEN_W'($urandom_range(1, len_cap()))));
      end
   endtask

   // disconnect with data still missing, final ack, then everything refused
   task automatic test_shutdown();
      logic [SEQ_W-1:0] base;
      base = next_seq;
      send_header(hdr(seq_word(base + 8'd2), 8'h00, CTL_DISCONNECT, 16'h0000));
      send_header(hdr(seq_word(base + 8'd1), 8'h00, CTL_DATA, 16'h0007));
      send_header(hdr(seq_word(base), 8'h00, CTL_DATA, 16'h0400));
      send_header(hdr(seq_word(base + 8'd2), 8'h00, CTL_DATA, 16'h0001));
      send_header(hdr(seq_word(base + 8'd3), 8'h00, CTL_DATA, 16'h0000));
      send_header(hdr(seq_word(base + 8'd4), 8'h00, CTL_DATA, 16'h0001));
      send_header(hdr(32'h0000_0000, 8'h00, CTL_CONNECT, 16'h0000));
      send_header(hdr(32'hFFFF_FFFF, 8'h00, CTL_DISCONNECT, 16'h0000));
      send_header(hdr(32'h0000_0001, 8'hFF, 8'hFF, 16'hFFFF));
   endtask

   initial begin
      foreach (slot_len[i]) slot_len[i] = '0;
      load_window('0);
      end_seen = 1'b0;
      end_seq = '0;
      link_up = 1'b0;
      transfer_done = 1'b0;
      cfg_max_len = LEN_CAP;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_link_down();
      // upper byte of the sequence write is ignored; end near the top for wrap
      program_registers(1'b1, 16'hA5FF, 1'b0, 16'h0000);
      program_registers(1'b1, 16'h00FC, 1'b1, LEN_CAP);
      test_connect();
      test_header_checks();
      test_window_wrap();

      // sender idles lightly, receiver stalls often
      program_registers(1'b1, 16'h0000, 1'b1, 16'hFFFF);
      test_random_traffic(95);

      // roles swapped
      send_idle_pct = 51;
      recv_stall_pct = 22;
      program_registers(1'b0, 16'h0000, 1'b1, 16'h0000);
      test_random_traffic(12);
      program_registers(1'b0, 16'h0000, 1'b1, LEN_W'($urandom_range(16, 1023)));
      test_random_traffic(95);

      // full rate
      send_idle_pct = 0;
      recv_stall_pct = 0;
      program_registers(1'b1, 16'h00FF, 1'b1, LEN_CAP);
      test_random_traffic(95);
      test_full_window();
      test_shutdown();

      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/swr_pkg.sv
sv/swr_ctrl.sv
sv/swr_dp.sv
sv/sliding_window_receiver_unit.sv
tb/sv/tb_sliding_window_receiver_unit.sv
